### design/gps_pkg.sv
package gps_pkg;

  localparam int UNIFORM_BITS = 32;
  localparam int UP_SHIFT     = 64 - 2 * UNIFORM_BITS;

  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TWO_LN2_Q62 = 64'h58B9_0BFB_E8E7_BCD6;
  localparam logic [63:0] LOG_TOP     = 64'(62) << 56;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REG_MEAN    = 2'd0;
  localparam logic [1:0] REG_STD_DEV = 2'd1;
  localparam logic [1:0] REG_MIN_SQ  = 2'd2;

  localparam logic signed [34:0] OUT_MAX = 35'sd8589934591;
  localparam logic signed [34:0] OUT_MIN = -35'sd8589934592;

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] std_dev;
    logic [62:0] min_square_sum;
  } gps_cfg_t;

  typedef struct packed {
    logic [62:0] w;
    logic [62:0] a2;
    logic        neg;
  } gps_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_ADJ,
    ST_T_MUL,
    ST_DIV,
    ST_RT_MUL,
    ST_SQRT,
    ST_SD_MUL,
    ST_FIN
  } gps_state_t;

endpackage

### design/gaussian_polar_sampler.sv
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------
// input     | in_valid / in_stall   | uniform_a, uniform_b
// result    | out_valid / out_stall | sample_value
// config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// the front takes one uniform pair per cycle while in_stall is low; rejected pairs are dropped
// accepted pairs queue (4 deep) for the back, which takes a new pair only once the last one is
// done; it uses the shared 32x32 multiplier, also in the 56-step log squaring loop
// reset is synchronous and active high; config resets to mean 0, std 1.0, floor 1
// in_stall rises only while the queue is full and a kept pair waits
module gaussian_polar_sampler import gps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        uniform_a,
  input  logic [31:0]        uniform_b,
  input  logic               in_valid,
  output logic               in_stall,
  output logic signed [33:0] sample_value,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  gps_cfg_t  cfg;
  logic      q_push, q_full, q_pop, q_valid;
  gps_item_t q_item, q_head;

  // config registers, always ready; unknown index ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean           <= 32'd0;
      cfg.std_dev        <= 32'd65536;
      cfg.min_square_sum <= 63'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEAN:    cfg.mean           <= cfg_data[31:0];
        REG_STD_DEV: cfg.std_dev        <= cfg_data[31:0];
        REG_MIN_SQ:  cfg.min_square_sum <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  // front: square, sum, reject and floor
  gps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .uniform_a (uniform_a),
    .uniform_b (uniform_b),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  // short queue decouples the front from the iterative back
  gps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back: log, divide, root, scale, with its own result register
  gps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_value (sample_value)
  );

endmodule

### design/gps_front.sv
module gps_front import gps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  gps_cfg_t    cfg,
  input  logic [31:0] uniform_a,
  input  logic [31:0] uniform_b,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        q_full,
  output logic        q_push,
  output gps_item_t   q_item
);

  localparam logic [UNIFORM_BITS-1:0] HALF = UNIFORM_BITS'(1) << (UNIFORM_BITS - 1);

  logic [UNIFORM_BITS-1:0] ua, ub, ma, mb;
  logic                    s1_valid;
  logic [63:0]             s1_a2, s1_b2;
  logic                    s1_neg;
  logic [63:0]             w_sum, floor_w, w_fl;
  logic                    keep;

  assign ua = uniform_a[UNIFORM_BITS-1:0];
  assign ub = uniform_b[UNIFORM_BITS-1:0];
  assign ma = (ua < HALF) ? HALF - ua : ua - HALF;
  assign mb = (ub < HALF) ? HALF - ub : ub - HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_a2  <= (64'(ma) * 64'(ma)) << UP_SHIFT;
      s1_b2  <= (64'(mb) * 64'(mb)) << UP_SHIFT;
      s1_neg <= ua < HALF;
    end
  end

  // reject zero and outside the unit circle, then apply the floor
  assign w_sum   = s1_a2 + s1_b2;
  assign keep    = (w_sum != 64'd0) && (w_sum <= ONE_Q62);
  assign floor_w = ({1'b0, cfg.min_square_sum} > ONE_Q62) ? ONE_Q62
                                                          : {1'b0, cfg.min_square_sum};
  assign w_fl    = (w_sum < floor_w) ? floor_w : w_sum;

  assign in_stall   = s1_valid && keep && q_full;
  assign q_push     = s1_valid && keep && !q_full;
  assign q_item.w   = w_fl[62:0];
  assign q_item.a2  = s1_a2[62:0];
  assign q_item.neg = s1_neg;

endmodule

### design/gps_queue.sv
module gps_queue import gps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  gps_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output gps_item_t head
);

  gps_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wr_ptr] <= push_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

### design/gps_back.sv
module gps_back import gps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  gps_cfg_t           cfg,
  input  logic               q_valid,
  input  gps_item_t          q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [33:0] sample_value
);

  gps_state_t  state, state_next;

  logic [62:0]  w_r;
  logic [62:0]  a2_r;
  logic         neg_r;
  logic [63:0]  f;
  logic [5:0]   n;
  logic [63:0]  lg;
  logic [5:0]   bit_idx;
  logic [63:0]  mx_x, mx_y;
  logic [2:0]   mcnt;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc, pp_wide;
  logic [31:0]  op_a, op_b;
  logic         mul_run, mul_done;
  logic [63:0]  rem, rem_s, rem_n;
  logic [62:0]  r, r_s, r_n;
  logic         dge;
  logic [5:0]   dcnt, scnt;
  logic [65:0]  srem, srem_s, trial;
  logic [63:0]  root, root_n;
  logic         sge;
  logic [63:0]  sq, f_adj, lg_adj;
  logic [20:0]  q;
  logic         fr;
  logic signed [34:0] val;
  logic         out_load;

  assign mul_run  = (state == ST_SQ_MUL) || (state == ST_T_MUL) ||
                    (state == ST_RT_MUL) || (state == ST_SD_MUL);
  assign mul_done = mcnt == 3'd4;

  // partial product select of the shared 32x32 multiplier
  always_comb begin
    case (mcnt[1:0])
      2'd0:    begin op_a = mx_x[31:0];  op_b = mx_y[31:0];  end
      2'd1:    begin op_a = mx_x[31:0];  op_b = mx_y[63:32]; end
      2'd2:    begin op_a = mx_x[63:32]; op_b = mx_y[31:0];  end
      default: begin op_a = mx_x[63:32]; op_b = mx_y[63:32]; end
    endcase
    case (pp_sh)
      2'd0:       pp_wide = {64'b0, pp};
      2'd1, 2'd2: pp_wide = {32'b0, pp, 32'b0};
      default:    pp_wide = {pp, 64'b0};
    endcase
  end

  // log squaring adjust
  assign sq     = acc[125:62];
  assign f_adj  = sq[63] ? {1'b0, sq[63:1]} : sq;
  assign lg_adj = lg | (sq[63] ? (64'd1 << bit_idx) : 64'd0);

  // restoring division step
  assign rem_s = (dcnt == 6'd0) ? rem : {rem[62:0], 1'b0};
  assign r_s   = (dcnt == 6'd0) ? r : {r[61:0], 1'b0};
  assign dge   = rem_s >= {1'b0, w_r};
  assign rem_n = dge ? rem_s - {1'b0, w_r} : rem_s;
  assign r_n   = r_s | {62'b0, dge};

  // digit-by-digit square root step
  assign srem_s = {srem[63:0], acc[127:126]};
  assign trial  = {root, 2'b01};
  assign sge    = srem_s >= trial;
  assign root_n = {root[62:0], sge};

  // final offset from mean, truncated toward zero
  assign q  = acc[95:75];
  assign fr = |acc[74:0];
  always_comb begin
    if (!neg_r) begin
      val = $signed({3'b0, cfg.mean}) + $signed({14'b0, q});
    end else begin
      val = $signed({3'b0, cfg.mean}) - $signed({14'b0, q})
            - $signed({34'b0, fr && ({11'b0, q} < cfg.mean)});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_NORM;
        end
      end
      ST_NORM:   if (f[62]) state_next = ST_SQ_MUL;
      ST_SQ_MUL: if (mul_done) state_next = ST_SQ_ADJ;
      ST_SQ_ADJ: state_next = (bit_idx == 6'd0) ? ST_T_MUL : ST_SQ_MUL;
      ST_T_MUL:  if (mul_done) state_next = ST_DIV;
      ST_DIV:    if (dcnt == 6'd62) state_next = ST_RT_MUL;
      ST_RT_MUL: if (mul_done) state_next = ST_SQRT;
      ST_SQRT:   if (scnt == 6'd63) state_next = ST_SD_MUL;
      ST_SD_MUL: if (mul_done) state_next = ST_FIN;
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_run) begin
      mcnt <= mcnt + 1'b1;
      if (mcnt < 3'd4) begin
        pp    <= op_a * op_b;
        pp_sh <= mcnt[1:0];
      end
      if (mcnt != 3'd0) acc <= acc + pp_wide;
    end
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          w_r   <= q_head.w;
          a2_r  <= q_head.a2;
          neg_r <= q_head.neg;
          f     <= {1'b0, q_head.w};
          n     <= 6'd62;
        end
      end
      ST_NORM: begin
        if (f[62]) begin
          lg      <= {2'b0, n, 56'b0};
          mx_x    <= f;
          mx_y    <= f;
          acc     <= '0;
          mcnt    <= '0;
          bit_idx <= 6'd55;
        end else if (f[62:55] == 8'd0) begin
          f <= {f[55:0], 8'b0};
          n <= n - 6'd8;
        end else begin
          f <= {f[62:0], 1'b0};
          n <= n - 6'd1;
        end
      end
      ST_SQ_ADJ: begin
        f    <= f_adj;
        lg   <= lg_adj;
        acc  <= '0;
        mcnt <= '0;
        if (bit_idx == 6'd0) begin
          mx_x <= LOG_TOP - lg_adj;
          mx_y <= TWO_LN2_Q62;
        end else begin
          bit_idx <= bit_idx - 6'd1;
          mx_x    <= f_adj;
          mx_y    <= f_adj;
        end
      end
      ST_T_MUL: begin
        if (mul_done) begin
          rem  <= {1'b0, a2_r};
          r    <= '0;
          dcnt <= '0;
        end
      end
      ST_DIV: begin
        rem  <= rem_n;
        r    <= r_n;
        dcnt <= dcnt + 6'd1;
        if (dcnt == 6'd62) begin
          // acc still holds -2 ln w from the previous product
          mx_x <= {1'b0, r_n};
          mx_y <= acc[125:62];
          acc  <= '0;
          mcnt <= '0;
        end
      end
      ST_RT_MUL: begin
        if (mul_done) begin
          root <= '0;
          srem <= '0;
          scnt <= '0;
        end
      end
      ST_SQRT: begin
        srem <= sge ? srem_s - trial : srem_s;
        root <= root_n;
        scnt <= scnt + 6'd1;
        if (scnt == 6'd63) begin
          mx_x <= {32'b0, cfg.std_dev};
          mx_y <= root_n;
          acc  <= '0;
          mcnt <= '0;
        end else begin
          acc <= {acc[125:0], 2'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      if (val > OUT_MAX) sample_value <= OUT_MAX[33:0];
      else if (val < OUT_MIN) sample_value <= OUT_MIN[33:0];
      else sample_value <= val[33:0];
    end
  end

`ifndef SYNTHESIS
  a_square_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ_ADJ) |-> (acc[127:126] == 2'b00))
    else $error("log square out of range");
  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ_MUL) |-> (mx_x[63:62] == 2'b01))
    else $error("mantissa not normalized");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten");
`endif

endmodule
